// ===== hw/rtl/jsm_pkg.sv =====
package jsm_pkg;

  localparam int COORD_BITS      = 12;
  localparam int SPEED_FRAC_BITS = 15;

  localparam int CW       = COORD_BITS;
  localparam int DW       = CW + 1;
  localparam int PW       = 2 * CW;
  localparam int L2W      = PW + 1;
  localparam int LEN_FRAC = 8;
  localparam int SQ_STEPS = (L2W + 2 * LEN_FRAC + 1) / 2;
  localparam int SQ_VW    = 2 * SQ_STEPS;
  localparam int RW       = SQ_STEPS;
  localparam int AW       = (L2W > RW + 3) ? L2W : RW + 3;
  localparam int NUMW     = PW + LEN_FRAC + 2;
  localparam int RQ_STEPS = DW;
  localparam int SP_STEPS = SPEED_FRAC_BITS + 1;
  localparam int DVW      = (RQ_STEPS > SP_STEPS) ? RQ_STEPS : SP_STEPS;
  localparam int CNTW     = $clog2(((SQ_STEPS > DVW) ? SQ_STEPS : DVW) + 2);
  localparam int SPW      = 16;
  localparam int CFG_IW   = 2;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IW-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IW-1:0] REG_RADIUS   = 2'd2;

  localparam logic [1:0] STEP_HOLD = 2'd0;
  localparam logic [1:0] STEP_SH1  = 2'd1;
  localparam logic [1:0] STEP_SH2  = 2'd2;

  typedef logic [CW-1:0]         coord_t;
  typedef logic signed [DW-1:0]  offset_t;
  typedef logic signed [SPW-1:0] speed_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t radius;
  } cfg_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [AW-1:0] rem;
    logic [1:0]    bits;
    logic [AW-1:0] sub;
  } step_req_t;

  typedef struct packed {
    logic          ge;
    logic [AW-1:0] res;
  } step_rsp_t;

endpackage

// ===== hw/rtl/jsm_evt_if.sv =====
interface jsm_evt_if import jsm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  coord_t     touch_x;
  coord_t     touch_y;

  modport source (output valid, output op, output touch_x, output touch_y, input ready);
  modport sink (input valid, input op, input touch_x, input touch_y, output ready);
endinterface

// ===== hw/rtl/jsm_res_if.sv =====
interface jsm_res_if import jsm_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    send_valid;
  speed_t  pan_speed;
  speed_t  tilt_speed;
  logic    pos_valid;
  offset_t pos_x;
  offset_t pos_y;
  logic    now_active;

  modport source (output valid, output send_valid, output pan_speed, output tilt_speed,
                  output pos_valid, output pos_x, output pos_y, output now_active,
                  input ready);
  modport sink (input valid, input send_valid, input pan_speed, input tilt_speed,
                input pos_valid, input pos_x, input pos_y, input now_active,
                output ready);
endinterface

// ===== hw/rtl/jsm_cfg_if.sv =====
interface jsm_cfg_if import jsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  coord_t            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/jsm_cfg.sv =====
module jsm_cfg import jsm_pkg::*; (
  input  logic clk,
  input  logic rst,
  jsm_cfg_if.sink cfg,
  output cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.center_x <= '0;
      regs.center_y <= '0;
      regs.radius   <= coord_t'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_CENTER_X: regs.center_x <= cfg.data;
        REG_CENTER_Y: regs.center_y <= cfg.data;
        REG_RADIUS:   regs.radius   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/jsm_step.sv =====
module jsm_step import jsm_pkg::*; (
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic [AW-1:0] t;
  logic          ge;

  // shift in new dividend / radicand bits (none in hold mode), then compare and conditionally subtract
  always_comb begin
    unique case (req.mode)
      STEP_HOLD: t = req.rem;
      STEP_SH1:  t = {req.rem[AW-2:0], req.bits[0]};
      STEP_SH2:  t = {req.rem[AW-3:0], req.bits};
      default:   t = req.rem;
    endcase
    ge      = (t >= req.sub);
    rsp.ge  = ge;
    rsp.res = ge ? (t - req.sub) : t;
  end

endmodule

// ===== hw/rtl/jsm_core.sv =====
module jsm_core import jsm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t regs,
  jsm_evt_if.sink   evt,
  jsm_res_if.source res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_RNUM = 3'd4;
  localparam logic [2:0] S_RDIV = 3'd5;
  localparam logic [2:0] S_SPD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [SP_STEPS-1:0] LIM_POS = {1'b0, {SPEED_FRAC_BITS{1'b1}}};
  localparam logic [SP_STEPS-1:0] LIM_NEG = {1'b1, {SPEED_FRAC_BITS{1'b0}}};

  function automatic coord_t mag_of(input offset_t v);
    offset_t n;
    n = -v;
    return v[DW-1] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  logic [2:0]      state;
  logic [CNTW-1:0] cnt;
  logic            engaged;
  logic            out_valid;

  logic [1:0]      op_q;
  offset_t         dx, dy;
  coord_t          ax, ay;
  logic [PW-1:0]   prod;
  logic [L2W-1:0]  len2;
  logic [SQ_VW-1:0] sqv;
  logic [RW-1:0]   root;
  logic [AW-1:0]   rem;
  logic [DVW-1:0]  dvd;
  logic            which;
  logic            spos;
  logic            send, posv;
  offset_t         px, py;
  speed_t          pan, tilt;

  logic            o_send, o_posv, o_active;
  speed_t          o_pan, o_tilt;
  offset_t         o_px, o_py;

  offset_t         in_dx, in_dy;
  coord_t          mul_a, mul_b;
  step_req_t       step_req;
  step_rsp_t       step_rsp;
  logic            in_circle;
  logic            r_zero;
  logic [DVW-1:0]  q_all;
  offset_t         pull;
  logic [NUMW-1:0] numv;
  offset_t         sel;
  coord_t          pmag;
  logic [SP_STEPS-1:0] smag, sat;
  speed_t          speed_val;
  logic            cmp_take, cmp_send, cmp_posv;

  assign evt.ready = (state == S_IDLE);

  assign in_dx = offset_t'({1'b0, evt.touch_x} - {1'b0, regs.center_x});
  assign in_dy = offset_t'({1'b0, evt.touch_y} - {1'b0, regs.center_y});

  assign r_zero    = (regs.radius == '0);
  assign in_circle = step_rsp.ge;

  // outcome of the circle check, before any clamping or speed work
  assign cmp_take = (op_q == OP_START && in_circle) || (op_q == OP_MOVE && engaged);
  assign cmp_send = cmp_take || (op_q == OP_STOP && engaged);
  assign cmp_posv = (op_q == OP_START) || (op_q == OP_STOP) || (op_q == OP_MOVE && engaged);

  // shared multiplier operand select
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    if (state == S_MUL && cnt == CNTW'(1)) begin
      mul_a = ay;
      mul_b = ay;
    end else if (state == S_MUL && cnt == CNTW'(2)) begin
      mul_a = regs.radius;
      mul_b = regs.radius;
    end else if (state == S_RNUM) begin
      mul_a = which ? ay : ax;
      mul_b = regs.radius;
    end
  end

  // shared step unit operand select
  always_comb begin
    step_req.mode = STEP_HOLD;
    step_req.rem  = rem;
    step_req.bits = {1'b0, dvd[DVW-1]};
    step_req.sub  = '0;
    unique case (state)
      S_CMP: begin
        step_req.rem = AW'(prod);
        step_req.sub = AW'(len2);
      end
      S_SQRT: begin
        step_req.mode = STEP_SH2;
        step_req.bits = sqv[SQ_VW-1 -: 2];
        step_req.sub  = AW'({root, 2'b01});
      end
      S_RDIV: begin
        step_req.mode = STEP_SH1;
        step_req.sub  = AW'({root, 1'b0});
      end
      S_SPD: begin
        step_req.mode = STEP_SH1;
        step_req.sub  = AW'(regs.radius);
      end
      default: ;
    endcase
  end

  jsm_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  assign q_all = {dvd[DVW-2:0], step_rsp.ge};
  assign pull  = (which ? dy[DW-1] : dx[DW-1]) ? -offset_t'(q_all[RQ_STEPS-1:0])
                                               :  offset_t'(q_all[RQ_STEPS-1:0]);

  // rounded pull onto the circle: (2*|d|*r*256 + len) / (2*len)
  assign numv = (NUMW'(prod) << (LEN_FRAC + 1)) + NUMW'(root);

  assign sel  = which ? py : px;
  assign pmag = mag_of(sel);
  assign smag = q_all[SP_STEPS-1:0];

  always_comb begin
    if (spos) begin
      sat = (smag > LIM_POS) ? LIM_POS : smag;
    end else begin
      sat = (smag > LIM_NEG) ? LIM_NEG : smag;
    end
    speed_val = spos ? speed_t'(sat) : -speed_t'(sat);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      engaged   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // load a finished event, drop once the result transfers
      if (state == S_OUT && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          if (cnt == CNTW'(2)) begin
            state <= S_CMP;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CMP: begin
          cnt <= '0;
          unique case (op_q)
            OP_START: begin
              engaged <= in_circle;
              state   <= (in_circle && !r_zero) ? S_SPD : S_OUT;
            end
            OP_MOVE: begin
              if (!engaged) begin
                state <= S_OUT;
              end else if (!in_circle) begin
                state <= S_SQRT;
              end else begin
                state <= r_zero ? S_OUT : S_SPD;
              end
            end
            OP_STOP: begin
              engaged <= 1'b0;
              state   <= S_OUT;
            end
            OP_UNUSED: state <= S_OUT;
          endcase
        end
        S_SQRT: begin
          if (cnt == CNTW'(SQ_STEPS - 1)) begin
            state <= S_RNUM;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RNUM: begin
          if (cnt == CNTW'(1)) begin
            state <= S_RDIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RDIV: begin
          if (cnt == CNTW'(RQ_STEPS - 1)) begin
            cnt <= '0;
            if (which) begin
              state <= r_zero ? S_OUT : S_SPD;
            end else begin
              state <= S_RNUM;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SPD: begin
          if (cnt == CNTW'(SP_STEPS)) begin
            cnt <= '0;
            if (which) begin
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
    unique case (state)
      S_IDLE: begin
        if (evt.valid) begin
          op_q <= evt.op;
          dx   <= in_dx;
          dy   <= in_dy;
          ax   <= mag_of(in_dx);
          ay   <= mag_of(in_dy);
        end
      end
      S_MUL: begin
        if (cnt == CNTW'(1)) begin
          len2 <= L2W'(prod);
        end else if (cnt == CNTW'(2)) begin
          len2 <= len2 + L2W'(prod);
        end
      end
      S_CMP: begin
        which <= 1'b0;
        pan   <= '0;
        tilt  <= '0;
        px    <= cmp_take ? dx : '0;
        py    <= cmp_take ? dy : '0;
        send  <= cmp_send;
        posv  <= cmp_posv;
        sqv   <= SQ_VW'(len2) << (2 * LEN_FRAC);
        root  <= '0;
        rem   <= '0;
      end
      S_SQRT: begin
        rem  <= step_rsp.res;
        root <= {root[RW-2:0], step_rsp.ge};
        sqv  <= sqv << 2;
      end
      S_RNUM: begin
        if (cnt == CNTW'(1)) begin
          rem <= AW'(numv >> RQ_STEPS);
          dvd <= DVW'(numv[RQ_STEPS-1:0]) << (DVW - RQ_STEPS);
        end
      end
      S_RDIV: begin
        rem <= step_rsp.res;
        dvd <= q_all;
        if (cnt == CNTW'(RQ_STEPS - 1)) begin
          if (which) begin
            py <= pull;
          end else begin
            px <= pull;
          end
          which <= ~which;
        end
      end
      S_SPD: begin
        if (cnt == '0) begin
          rem  <= AW'(pmag >> 1);
          dvd  <= DVW'({pmag[0], {SPEED_FRAC_BITS{1'b0}}}) << (DVW - SP_STEPS);
          // tilt is taken from the negated y offset
          spos <= which ? py[DW-1] : !px[DW-1];
        end else begin
          rem <= step_rsp.res;
          dvd <= q_all;
          if (cnt == CNTW'(SP_STEPS)) begin
            if (which) begin
              tilt <= speed_val;
            end else begin
              pan <= speed_val;
            end
            which <= ~which;
          end
        end
      end
      S_OUT: begin
        if (!out_valid || res.ready) begin
          o_send   <= send;
          o_pan    <= pan;
          o_tilt   <= tilt;
          o_posv   <= posv;
          o_px     <= px;
          o_py     <= py;
          o_active <= engaged;
        end
      end
      default: ;
    endcase
  end

  assign res.valid      = out_valid;
  assign res.send_valid = o_send;
  assign res.pan_speed  = o_pan;
  assign res.tilt_speed = o_tilt;
  assign res.pos_valid  = o_posv;
  assign res.pos_x      = o_px;
  assign res.pos_y      = o_py;
  assign res.now_active = o_active;

endmodule

// ===== hw/rtl/touch_joystick_speed_mapper.sv =====
// A start or move inside the circle at nonzero radius runs two 16-step speed divisions on the
// shared step unit; a move clamped onto the circle first adds a 21-step square root and two
// 13-step divisions, and skips the speed divisions at zero radius; all other events use
// neither.
// One event in flight; the next is taken the cycle after the result is registered.
// Synchronous reset: not engaged, center 0/0, radius 1, no result pending.
module touch_joystick_speed_mapper import jsm_pkg::*; (
  input logic clk,
  input logic rst,
  jsm_evt_if.sink   evt,
  jsm_res_if.source res,
  jsm_cfg_if.sink   cfg
);

  cfg_t regs;

  jsm_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  jsm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .evt  (evt),
    .res  (res)
  );

endmodule

// ===== hw/rtl/jsm_checker.sv =====
module jsm_checker import jsm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    evt_valid,
  input logic    evt_ready,
  input logic    res_valid,
  input logic    send_valid,
  input speed_t  pan_speed,
  input speed_t  tilt_speed,
  input logic    pos_valid,
  input offset_t pos_x,
  input offset_t pos_y
);

  // one event at a time: busy right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> !evt_ready)
    else $error("event taken while busy");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result pending after reset");

  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !send_valid |-> pan_speed == '0 && tilt_speed == '0)
    else $error("speed nonzero without send");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !pos_valid |-> pos_x == '0 && pos_y == '0)
    else $error("position nonzero without update");

  a_send_implies_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && send_valid |-> pos_valid)
    else $error("speed sent without position update");

endmodule

bind touch_joystick_speed_mapper jsm_checker u_jsm_checker (
  .clk        (clk),
  .rst        (rst),
  .evt_valid  (evt.valid),
  .evt_ready  (evt.ready),
  .res_valid  (res.valid),
  .send_valid (res.send_valid),
  .pan_speed  (res.pan_speed),
  .tilt_speed (res.tilt_speed),
  .pos_valid  (res.pos_valid),
  .pos_x      (res.pos_x),
  .pos_y      (res.pos_y)
);

// ===== tb/touch_joystick_speed_mapper_tb.sv =====
`timescale 1ns / 100ps

module touch_joystick_speed_mapper_tb;
  import jsm_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam longint SPEED_POS    = (longint'(1) << SPEED_FRAC_BITS) - 1;
  localparam longint SPEED_NEG    = longint'(1) << SPEED_FRAC_BITS;
  localparam int     RANDOM_ITEMS = 400;

  typedef struct packed {
    logic    send_valid;
    speed_t  pan_speed;
    speed_t  tilt_speed;
    logic    pos_valid;
    offset_t pos_x;
    offset_t pos_y;
    logic    now_active;
  } joy_result_t;

  logic clk = 1'b0;
  logic rst;

  jsm_evt_if evt ();
  jsm_res_if res ();
  jsm_cfg_if cfg ();

  touch_joystick_speed_mapper DUT (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  // joystick state as the block should hold it
  coord_t cfg_cx;
  coord_t cfg_cy;
  coord_t cfg_radius;
  bit     knob_engaged;

  joy_result_t pending_reports[$];
  int          fail_count  = 0;
  int          events_sent = 0;
  int          cycle_count = 0;
  int          recv_hold   = 0;
  bit          calm_send   = 0;
  bit          calm_recv   = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = acc | (longint'(1) << b);
      if (trial * trial <= v)
        acc = trial;
    end
    return acc;
  endfunction

  // d * r / |len|, with len in Q8; halves round away from zero
  function automatic longint onto_circle(longint d, longint r, longint unsigned len_q8);
    longint unsigned num;
    longint unsigned q;
    if (len_q8 == 0)
      return 0;
    num = longint'(d < 0 ? -d : d) * r * 256;
    q = (2 * num + len_q8) / (2 * len_q8);
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic speed_t speed_of(longint d, longint r);
    longint mag;
    if (r == 0)
      return '0;
    mag = ((d < 0 ? -d : d) << SPEED_FRAC_BITS) / r;
    if (d >= 0)
      return speed_t'(mag > SPEED_POS ? SPEED_POS : mag);
    return speed_t'(-(mag > SPEED_NEG ? SPEED_NEG : mag));
  endfunction

  function automatic joy_result_t joystick_response(logic [1:0] op, coord_t tx, coord_t ty);
    longint          dx;
    longint          dy;
    longint          rr;
    longint          len2;
    longint          px;
    longint          py;
    longint unsigned len_q8;
    bit              outside;
    bit              send;
    joy_result_t     r;
    dx      = longint'(tx) - longint'(cfg_cx);
    dy      = longint'(ty) - longint'(cfg_cy);
    rr      = longint'(cfg_radius);
    len2    = dx * dx + dy * dy;
    outside = len2 > rr * rr;
    r       = '0;
    send    = 0;
    px      = 0;
    py      = 0;
    case (op)
      OP_START: begin
        r.pos_valid = 1'b1;
        if (outside) begin
          knob_engaged = 0;
        end else begin
          knob_engaged = 1;
          send = 1;
          px = dx;
          py = dy;
        end
      end
      OP_MOVE: begin
        if (knob_engaged) begin
          r.pos_valid = 1'b1;
          send = 1;
          px = dx;
          py = dy;
          if (outside) begin
            len_q8 = root_floor(longint'(len2) << 16);
            px = onto_circle(dx, rr, len_q8);
            py = onto_circle(dy, rr, len_q8);
          end
        end
      end
      OP_STOP: begin
        r.pos_valid = 1'b1;
        if (knob_engaged) begin
          send = 1;
          knob_engaged = 0;
        end
      end
      default: ;
    endcase
    r.send_valid = send;
    if (send) begin
      r.pan_speed  = speed_of(px, rr);
      r.tilt_speed = speed_of(-py, rr);
    end
    r.pos_x      = offset_t'(px);
    r.pos_y      = offset_t'(py);
    r.now_active = knob_engaged;
    return r;
  endfunction

  function automatic coord_t near_point(coord_t c, int span);
    int lo;
    int hi;
    lo = int'(c) - span;
    hi = int'(c) + span;
    if (lo < 0)
      lo = 0;
    if (hi > COORD_MAX)
      hi = COORD_MAX;
    return coord_t'($urandom_range(hi, lo));
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10)
      $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_event(logic [1:0] op, coord_t tx, coord_t ty);
    int gap;
    gap = calm_send ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt.valid   <= 1'b1;
    evt.op      <= op;
    evt.touch_x <= tx;
    evt.touch_y <= ty;
    do @(posedge clk); while (!evt.ready);
    pending_reports.push_back(joystick_response(op, tx, ty));
    events_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    evt.valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, coord_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_CENTER_X: cfg_cx = val;
      REG_CENTER_Y: cfg_cy = val;
      REG_RADIUS:   cfg_radius = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_joystick(coord_t cx, coord_t cy, coord_t r);
    drain_results();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
  endtask

  // reset config: center at the origin, radius 1
  task automatic test_reset_defaults();
    send_event(OP_MOVE, 12'd5, 12'd5);
    send_event(OP_STOP, 12'd0, 12'd0);
    send_event(OP_START, 12'd1, 12'd0);
    send_event(OP_MOVE, 12'd4095, 12'd4095);
    send_event(OP_UNUSED, 12'd7, 12'd7);
    send_event(OP_MOVE, 12'd0, 12'd1);
    send_event(OP_STOP, 12'd0, 12'd0);
    send_event(OP_START, 12'd1, 12'd1);
  endtask

  task automatic test_circle_edges();
    set_joystick(12'd2048, 12'd2048, 12'd4095);
    send_event(OP_START, 12'd0, 12'd0);
    send_event(OP_MOVE, 12'd4095, 12'd4095);
    send_event(OP_MOVE, 12'd0, 12'd4095);
    send_event(OP_STOP, 12'd0, 12'd0);
    // exactly on the circle counts as inside
    set_joystick(12'd0, 12'd0, 12'd4095);
    send_event(OP_START, 12'd4095, 12'd0);
    send_event(OP_MOVE, 12'd4095, 12'd4095);
    set_joystick(12'd4095, 12'd4095, 12'd1);
    send_event(OP_START, 12'd4094, 12'd4095);
    send_event(OP_MOVE, 12'd0, 12'd0);
    send_event(OP_STOP, 12'd0, 12'd0);
  endtask

  task automatic test_zero_radius();
    set_joystick(12'd100, 12'd3000, 12'd0);
    send_event(OP_START, 12'd100, 12'd3000);
    send_event(OP_MOVE, 12'd103, 12'd3000);
    send_event(OP_UNUSED, 12'd0, 12'd0);
    send_event(OP_STOP, 12'd0, 12'd0);
    send_event(OP_START, 12'd101, 12'd3000);
  endtask

  task automatic test_backpressure();
    set_joystick(12'd1000, 12'd1000, 12'd200);
    calm_send = 1;
    recv_hold = 300;
    send_event(OP_START, 12'd1050, 12'd980);
    send_event(OP_MOVE, 12'd1500, 12'd700);
    send_event(OP_MOVE, 12'd900, 12'd1100);
    send_event(OP_MOVE, 12'd4095, 12'd0);
    send_event(OP_STOP, 12'd0, 12'd0);
    send_event(OP_MOVE, 12'd1000, 12'd1000);
    calm_send = 0;
  endtask

  task automatic test_random_sessions(int n_items);
    int     last;
    int     seg_end;
    int     moves;
    int     span;
    coord_t r;
    last = events_sent + n_items;
    while (events_sent < last) begin
      case ($urandom_range(3))
        0:       r = coord_t'($urandom_range(16, 1));
        1:       r = coord_t'($urandom_range(512, 17));
        2:       r = coord_t'($urandom_range(COORD_MAX, 513));
        default: r = coord_t'($urandom_range(COORD_MAX));
      endcase
      set_joystick(coord_t'($urandom_range(COORD_MAX)), coord_t'($urandom_range(COORD_MAX)), r);
      calm_send = ($urandom_range(3) == 0);
      calm_recv = ($urandom_range(3) == 0);
      seg_end = events_sent + $urandom_range(60, 30);
      while (events_sent < seg_end && events_sent < last) begin
        if ($urandom_range(9) == 0) begin
          send_event(2'($urandom_range(3)), coord_t'($urandom_range(COORD_MAX)),
                     coord_t'($urandom_range(COORD_MAX)));
        end else begin
          send_event(OP_START, near_point(cfg_cx, cfg_radius), near_point(cfg_cy, cfg_radius));
          moves = $urandom_range(6);
          repeat (moves) begin
            case ($urandom_range(2))
              0:       span = cfg_radius;
              1:       span = 2 * cfg_radius + 2;
              default: span = COORD_MAX;
            endcase
            send_event(OP_MOVE, near_point(cfg_cx, span), near_point(cfg_cy, span));
          end
          if ($urandom_range(4) != 0)
            send_event(OP_STOP, coord_t'($urandom_range(COORD_MAX)),
                       coord_t'($urandom_range(COORD_MAX)));
        end
      end
    end
    calm_send = 0;
    calm_recv = 0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : result_check
    int          stall;
    joy_result_t want;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        stall = recv_hold;
        recv_hold = 0;
      end else begin
        stall = calm_recv ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && res.ready));
      if (pending_reports.size() == 0) begin
        note_failure("result transfer with no event pending");
      end else begin
        want = pending_reports.pop_front();
        compare_field("send_valid", want.send_valid, res.send_valid);
        compare_field("pan_speed", want.pan_speed, res.pan_speed);
        compare_field("tilt_speed", want.tilt_speed, res.tilt_speed);
        compare_field("pos_valid", want.pos_valid, res.pos_valid);
        compare_field("pos_x", want.pos_x, res.pos_x);
        compare_field("pos_y", want.pos_y, res.pos_y);
        compare_field("now_active", want.now_active, res.now_active);
      end
    end
  end

  initial begin
    rst          = 1'b1;
    evt.valid    = 1'b0;
    evt.op       = OP_START;
    evt.touch_x  = '0;
    evt.touch_y  = '0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_CENTER_X;
    cfg.data     = '0;
    cfg_cx       = '0;
    cfg_cy       = '0;
    cfg_radius   = coord_t'(1);
    knob_engaged = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_circle_edges();
    test_zero_radius();
    test_backpressure();
    test_random_sessions(RANDOM_ITEMS);

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/jsm_pkg.sv
hw/rtl/jsm_evt_if.sv
hw/rtl/jsm_res_if.sv
hw/rtl/jsm_cfg_if.sv
hw/rtl/jsm_cfg.sv
hw/rtl/jsm_step.sv
hw/rtl/jsm_core.sv
hw/rtl/touch_joystick_speed_mapper.sv
hw/rtl/jsm_checker.sv
tb/touch_joystick_speed_mapper_tb.sv
